// ----- design/cod_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cod_pkg;

  localparam int unsigned CHANNEL_COUNT_DEF = 16;
  localparam int unsigned NOTE_COUNT_DEF    = 128;

  localparam int unsigned OP_W      = 3;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned HALF_W    = 64;
  localparam int unsigned NOTES_MAX = 128;
  localparam int unsigned WINDOW_W  = 32;
  localparam int unsigned MIN_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [WINDOW_W-1:0] CHORD_WINDOW_RST = 32'd50000;
  localparam logic [MIN_W-1:0]    MIN_NOTES_RST    = 8'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHORD_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_NOTES    = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON     = 3'd0,
    OP_NOTE_OFF    = 3'd1,
    OP_SUSTAIN_ON  = 3'd2,
    OP_SUSTAIN_OFF = 3'd3,
    OP_TICK        = 3'd4,
    OP_CLEAR       = 3'd5
  } cod_op_e;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAN_W-1:0] channel;
    logic [NOTE_W-1:0] note;
    logic [TIME_W-1:0] event_time;
  } cod_in_t;

  typedef struct packed {
    logic              chord_valid;
    logic [HALF_W-1:0] chord_low;
    logic [HALF_W-1:0] chord_high;
    logic [TIME_W-1:0] chord_start;
    logic [TIME_W-1:0] chord_last;
    logic [HALF_W-1:0] sounding_low;
    logic [HALF_W-1:0] sounding_high;
    logic [HALF_W-1:0] held_low;
    logic [HALF_W-1:0] held_high;
  } cod_out_t;

endpackage

`default_nettype wire

// ----- design/chord_onset_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Chord onset detector.
// Input channel (in_valid_i / in_ready_o, in_item_i) takes one MIDI-style event per
// transaction; every event yields exactly one result transaction on the output
// channel (out_valid_o / out_ready_i, out_item_o), in order.
// Configuration channel (cfg_valid_i / cfg_ready_o) writes chord_window (index 0)
// or min_notes (index 1); it is always ready and should only be used while idle.
// The result is registered and presented in the cycle after its event is accepted.
// Throughput: one event per cycle; the per-note, per-channel key cells, the
// channel OR reduction and the popcount of the sounding set all fit in one pass
// between the state registers and the result register.
// A single result register parts the two sides: a new event is taken whenever
// that register is empty or is being emptied in the same cycle. When the
// receiver stalls, the result holds and the input channel stalls with it.
// Reset clears all key maps, pedal flags, the pending chord and the time
// reference, and sets chord_window to 50000 us and min_notes to 1.
module chord_onset_detector
  import cod_pkg::*;
#(
  parameter int unsigned CHANNEL_COUNT = CHANNEL_COUNT_DEF,
  parameter int unsigned NOTE_COUNT    = NOTE_COUNT_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire cod_in_t               in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output cod_out_t                   out_item_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CHANNEL_COUNT-1:0] held_q [NOTE_COUNT];
  logic [CHANNEL_COUNT-1:0] held_d [NOTE_COUNT];
  logic [CHANNEL_COUNT-1:0] sust_q [NOTE_COUNT];
  logic [CHANNEL_COUNT-1:0] sust_d [NOTE_COUNT];
  logic [CHANNEL_COUNT-1:0] pedal_q, pedal_d;
  logic                     pend_q, pend_d;
  logic [TIME_W-1:0]        pend_start_q, pend_start_d;
  logic [TIME_W-1:0]        pend_last_q, pend_last_d;
  logic [TIME_W-1:0]        latest_q, latest_d;
  logic [NOTES_MAX-1:0]     snd_q, snd_d;
  logic [NOTES_MAX-1:0]     hld_d;
  logic [WINDOW_W-1:0]      window_q;
  logic [MIN_W-1:0]         min_notes_q;
  logic                     out_valid_q;
  cod_out_t                 out_q, out_d;

  logic                     in_fire;
  logic                     is_clear;
  logic                     ch_ok, note_ok;
  logic                     act_on, act_other;
  logic [TIME_W-1:0]        t_eff;
  logic [TIME_W-1:0]        elapsed;
  logic                     complete;
  logic                     emit;
  logic                     pend_mid;

  logic [3:0] cnt8   [16];
  logic [4:0] cnt16  [8];
  logic [5:0] cnt32  [4];
  logic [6:0] cnt64  [2];
  logic [7:0] cnt128;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign is_clear  = (in_item_i.op == OP_CLEAR);
  assign ch_ok     = {1'b0, in_item_i.channel} < (CHAN_W + 1)'(CHANNEL_COUNT);
  assign note_ok   = {1'b0, in_item_i.note} < (NOTE_W + 1)'(NOTE_COUNT);
  assign act_on    = (in_item_i.op == OP_NOTE_ON) && ch_ok && note_ok;
  assign act_other = ch_ok && (((in_item_i.op == OP_NOTE_OFF) && note_ok) ||
                               (in_item_i.op == OP_SUSTAIN_ON) ||
                               (in_item_i.op == OP_SUSTAIN_OFF));

  assign t_eff    = (in_item_i.event_time < latest_q) ? latest_q : in_item_i.event_time;
  assign elapsed  = t_eff - pend_start_q;
  assign complete = pend_q && (elapsed >= {{(TIME_W - WINDOW_W){1'b0}}, window_q});

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      cnt8[i] = '0;
      for (int b = 0; b < 8; b++) begin
        cnt8[i] = cnt8[i] + 4'(snd_q[i*8 + b]);
      end
    end
    for (int i = 0; i < 8; i++) begin
      cnt16[i] = {1'b0, cnt8[2*i]} + {1'b0, cnt8[2*i + 1]};
    end
    for (int i = 0; i < 4; i++) begin
      cnt32[i] = {1'b0, cnt16[2*i]} + {1'b0, cnt16[2*i + 1]};
    end
    for (int i = 0; i < 2; i++) begin
      cnt64[i] = {1'b0, cnt32[2*i]} + {1'b0, cnt32[2*i + 1]};
    end
    cnt128 = {1'b0, cnt64[0]} + {1'b0, cnt64[1]};
  end

  assign emit     = complete && (cnt128 >= min_notes_q);
  assign pend_mid = pend_q && !complete;

  always_comb begin
    for (int n = 0; n < NOTE_COUNT; n++) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        held_d[n][c] = held_q[n][c];
        sust_d[n][c] = sust_q[n][c];
        if (is_clear) begin
          held_d[n][c] = 1'b0;
          sust_d[n][c] = 1'b0;
        end else if (in_item_i.channel == CHAN_W'(c)) begin
          if ((in_item_i.op == OP_NOTE_ON) && (in_item_i.note == NOTE_W'(n))) begin
            held_d[n][c] = 1'b1;
            sust_d[n][c] = 1'b0;
          end else if ((in_item_i.op == OP_NOTE_OFF) &&
                       (in_item_i.note == NOTE_W'(n))) begin
            held_d[n][c] = 1'b0;
            sust_d[n][c] = pedal_q[c];
          end else if (in_item_i.op == OP_SUSTAIN_OFF) begin
            sust_d[n][c] = sust_q[n][c] & held_q[n][c];
          end
        end
      end
    end
  end

  always_comb begin
    pedal_d = pedal_q;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      if (is_clear) begin
        pedal_d[c] = 1'b0;
      end else if (in_item_i.channel == CHAN_W'(c)) begin
        if (in_item_i.op == OP_SUSTAIN_ON) begin
          pedal_d[c] = 1'b1;
        end else if (in_item_i.op == OP_SUSTAIN_OFF) begin
          pedal_d[c] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    snd_d = '0;
    hld_d = '0;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      snd_d[n] = |(held_d[n] | sust_d[n]);
      hld_d[n] = |held_d[n];
    end
  end

  always_comb begin
    pend_d       = pend_mid;
    pend_start_d = pend_start_q;
    pend_last_d  = pend_last_q;
    latest_d     = t_eff;
    if (is_clear) begin
      pend_d       = 1'b0;
      pend_start_d = '0;
      pend_last_d  = '0;
      latest_d     = '0;
    end else if (act_on) begin
      pend_d      = 1'b1;
      pend_last_d = t_eff;
      if (!pend_mid) begin
        pend_start_d = t_eff;
      end
    end else if (act_other && pend_mid) begin
      pend_last_d = t_eff;
    end
  end

  always_comb begin
    out_d = '0;
    if (!is_clear) begin
      if (emit) begin
        out_d.chord_valid = 1'b1;
        out_d.chord_low   = snd_q[HALF_W-1:0];
        out_d.chord_high  = snd_q[NOTES_MAX-1:HALF_W];
        out_d.chord_start = pend_start_q;
        out_d.chord_last  = pend_last_q;
      end
      out_d.sounding_low  = snd_d[HALF_W-1:0];
      out_d.sounding_high = snd_d[NOTES_MAX-1:HALF_W];
      out_d.held_low      = hld_d[HALF_W-1:0];
      out_d.held_high     = hld_d[NOTES_MAX-1:HALF_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < NOTE_COUNT; n++) begin
        held_q[n] <= '0;
        sust_q[n] <= '0;
      end
      pedal_q      <= '0;
      pend_q       <= 1'b0;
      pend_start_q <= '0;
      pend_last_q  <= '0;
      latest_q     <= '0;
      snd_q        <= '0;
    end else if (in_fire) begin
      for (int n = 0; n < NOTE_COUNT; n++) begin
        held_q[n] <= held_d[n];
        sust_q[n] <= sust_d[n];
      end
      pedal_q      <= pedal_d;
      pend_q       <= pend_d;
      pend_start_q <= pend_start_d;
      pend_last_q  <= pend_last_d;
      latest_q     <= latest_d;
      snd_q        <= snd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= CHORD_WINDOW_RST;
      min_notes_q <= MIN_NOTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CHORD_WINDOW: window_q    <= cfg_data_i[WINDOW_W-1:0];
        CFG_MIN_NOTES:    min_notes_q <= cfg_data_i[MIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ----- bench/chord_onset_detector_tb.sv -----
`timescale 1ns / 1ps

module chord_onset_detector_tb;
  import cod_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD = 400;

  class chord_tracker;
    logic [NOTES_MAX-1:0] held [CHANNEL_COUNT_DEF];
    logic [NOTES_MAX-1:0] lingering [CHANNEL_COUNT_DEF];
    logic [CHANNEL_COUNT_DEF-1:0] pedal;
    bit window_open;
    logic [TIME_W-1:0] open_time;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] now;
    logic [WINDOW_W-1:0] window_len;
    logic [MIN_W-1:0] min_count;
    cod_out_t due_reports[$];
    int failures;

    function new();
      clear_keys();
      window_len = CHORD_WINDOW_RST;
      min_count = MIN_NOTES_RST;
      failures = 0;
    endfunction

    function void clear_keys();
      foreach (held[c]) begin
        held[c] = '0;
        lingering[c] = '0;
      end
      pedal = '0;
      window_open = 1'b0;
      open_time = '0;
      last_time = '0;
      now = '0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_CHORD_WINDOW) begin
        window_len = data[WINDOW_W-1:0];
      end else if (idx == CFG_MIN_NOTES) begin
        min_count = data[MIN_W-1:0];
      end
    endfunction

    function logic [NOTES_MAX-1:0] keys_down(bit with_pedal);
      logic [NOTES_MAX-1:0] acc;
      acc = '0;
      foreach (held[c]) begin
        acc |= held[c];
        if (with_pedal) acc |= lingering[c];
      end
      return acc;
    endfunction

    function int outstanding();
      return due_reports.size();
    endfunction

    function void queue_report(cod_out_t r);
      due_reports = {due_reports, r};
    endfunction

    function void take_event(cod_in_t ev);
      cod_out_t r;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] span;
      logic [NOTES_MAX-1:0] ring;
      logic [NOTES_MAX-1:0] down;
      int ch;
      int nt;
      bit keyed;
      r = '0;
      if (ev.op == OP_CLEAR) begin
        clear_keys();
        queue_report(r);
        return;
      end
      t = (ev.event_time < now) ? now : ev.event_time;
      span = t - open_time;
      if (window_open && span >= TIME_W'(window_len)) begin
        ring = keys_down(1'b1);
        if ($countones(ring) >= min_count) begin
          r.chord_valid = 1'b1;
          r.chord_low = ring[HALF_W-1:0];
          r.chord_high = ring[NOTES_MAX-1:HALF_W];
          r.chord_start = open_time;
          r.chord_last = last_time;
        end
        window_open = 1'b0;
      end
      ch = ev.channel;
      nt = ev.note;
      keyed = ev.op <= OP_SUSTAIN_OFF && ch < CHANNEL_COUNT_DEF &&
              !(ev.op <= OP_NOTE_OFF && nt >= NOTE_COUNT_DEF);
      if (keyed) begin
        case (ev.op)
          OP_NOTE_ON: begin
            if (!window_open) begin
              window_open = 1'b1;
              open_time = t;
            end
            held[ch][nt] = 1'b1;
            lingering[ch][nt] = 1'b0;
          end
          OP_NOTE_OFF: begin
            held[ch][nt] = 1'b0;
            lingering[ch][nt] = pedal[ch];
          end
          OP_SUSTAIN_ON: begin
            pedal[ch] = 1'b1;
          end
          default: begin
            pedal[ch] = 1'b0;
            lingering[ch] &= held[ch];
          end
        endcase
        if (window_open) last_time = t;
      end
      now = t;
      ring = keys_down(1'b1);
      down = keys_down(1'b0);
      r.sounding_low = ring[HALF_W-1:0];
      r.sounding_high = ring[NOTES_MAX-1:HALF_W];
      r.held_low = down[HALF_W-1:0];
      r.held_high = down[NOTES_MAX-1:HALF_W];
      queue_report(r);
    endfunction

    function void compare_field(string name, logic [HALF_W-1:0] want, logic [HALF_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        failures++;
      end
    endfunction

    function void match_report(cod_out_t got);
      cod_out_t want;
      if (due_reports.size() == 0) begin
        $error("result transaction with no event outstanding");
        failures++;
        return;
      end
      want = due_reports.pop_front();
      compare_field("chord_valid", HALF_W'(want.chord_valid), HALF_W'(got.chord_valid));
      compare_field("chord_low", want.chord_low, got.chord_low);
      compare_field("chord_high", want.chord_high, got.chord_high);
      compare_field("chord_start", HALF_W'(want.chord_start), HALF_W'(got.chord_start));
      compare_field("chord_last", HALF_W'(want.chord_last), HALF_W'(got.chord_last));
      compare_field("sounding_low", want.sounding_low, got.sounding_low);
      compare_field("sounding_high", want.sounding_high, got.sounding_high);
      compare_field("held_low", want.held_low, got.held_low);
      compare_field("held_high", want.held_high, got.held_high);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cod_in_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cod_out_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  chord_tracker tracker = new();
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned results_seen = 0;
  int unsigned gap_ahead = 0;
  logic [TIME_W-1:0] event_clock = '0;
  logic [WINDOW_W-1:0] window_now = CHORD_WINDOW_RST;

  chord_onset_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic cod_in_t key_event(logic [OP_W-1:0] op, int ch, int nt,
                                        logic [TIME_W-1:0] t);
    cod_in_t ev;
    ev.op = op;
    ev.channel = CHAN_W'(ch);
    ev.note = NOTE_W'(nt);
    ev.event_time = t;
    return ev;
  endfunction

  function automatic cod_in_t random_event();
    cod_in_t ev;
    int pick;
    int choice;
    logic [TIME_W:0] ahead;
    pick = $urandom_range(0, 99);
    ev.channel = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom) : CHAN_W'($urandom_range(0, 2));
    ev.note = ($urandom_range(0, 2) == 0) ? NOTE_W'($urandom) : NOTE_W'($urandom_range(58, 69));
    if (pick < 36) ev.op = OP_NOTE_ON;
    else if (pick < 60) ev.op = OP_NOTE_OFF;
    else if (pick < 68) ev.op = OP_SUSTAIN_ON;
    else if (pick < 76) ev.op = OP_SUSTAIN_OFF;
    else if (pick < 94) ev.op = OP_TICK;
    else if (pick < 96) ev.op = OP_CLEAR;
    else ev.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
    choice = $urandom_range(0, 39);
    if (choice < 3) begin
      ev.event_time = (event_clock > 3000) ? event_clock - $urandom_range(0, 3000) : '0;
    end else begin
      if (choice == 3) begin
        ahead = {1'b0, TIME_W'({$urandom, $urandom})};
      end else if (choice < 8) begin
        ahead = {1'b0, event_clock} + window_now + $urandom_range(0, window_now / 4);
      end else begin
        ahead = {1'b0, event_clock} + $urandom_range(0, window_now / 6);
      end
      ev.event_time = ahead[TIME_W-1:0];
      if (ahead[TIME_W]) begin
        ev.op = OP_CLEAR;
      end else if (ahead[TIME_W-1:0] > event_clock) begin
        event_clock = ahead[TIME_W-1:0];
      end
    end
    if (ev.op == OP_CLEAR) event_clock = TIME_W'($urandom_range(0, 1000));
    return ev;
  endfunction

  task automatic send_event(input cod_in_t ev, input bit pause_after);
    repeat (gap_ahead) @(posedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_event(ev);
    sent_count++;
    gap_ahead = ((sent_count / 90) % 4 == 3) ? 0 : $urandom_range(0, 8);
    if (pause_after || gap_ahead != 0) in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [WINDOW_W-1:0] window,
                               input logic [MIN_W-1:0] least);
    logic [CFG_DATA_W-1:0] word;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_CHORD_WINDOW;
    cfg_data_i <= CFG_DATA_W'(window);
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(CFG_CHORD_WINDOW, CFG_DATA_W'(window));
    word = $urandom;
    word[MIN_W-1:0] = least;
    cfg_index_i <= CFG_MIN_NOTES;
    cfg_data_i <= word;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_register(CFG_MIN_NOTES, word);
    cfg_valid_i <= 1'b0;
    window_now = window;
  endtask

  initial begin : result_side
    int unsigned gap;
    while (!rst_ni) @(posedge clk_i);
    out_ready_i <= 1'b1;
    forever begin
      do @(posedge clk_i); while (!out_valid_o);
      tracker.match_report(out_item_o);
      results_seen++;
      if (results_seen == 300 || results_seen == 1000) gap = LONG_HOLD;
      else if ((results_seen / 150) % 4 == 1) gap = 0;
      else gap = $urandom_range(0, 8);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : event_side
    cod_in_t opening [$];
    logic [WINDOW_W-1:0] windows [7];
    logic [MIN_W-1:0] leasts [7];
    int per_phase;
    bit stop_here;
    windows = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd200, 32'd5000, 32'd20000, 32'd50000};
    leasts = '{8'd1, 8'd2, 8'd3, 8'd0, 8'd128, 8'd255, 8'd1};
    per_phase = 230;
    opening = '{
      key_event(OP_NOTE_ON, 0, 0, 48'd100),
      key_event(OP_NOTE_ON, 15, 127, 48'd200),
      key_event(OP_NOTE_ON, 5, 63, 48'd150),
      key_event(OP_NOTE_ON, 5, 64, 48'd300),
      key_event(OP_SUSTAIN_ON, 5, 0, 48'd400),
      key_event(OP_NOTE_OFF, 5, 63, 48'd500),
      key_event(OP_TICK, 10, 85, 48'd50100),
      key_event(OP_NOTE_OFF, 0, 0, 48'd50200),
      key_event(OP_SUSTAIN_OFF, 5, 0, 48'd50300),
      key_event(OP_SPARE_LO, 3, 42, 48'd50400),
      key_event(OP_SPARE_HI, 10, 85, 48'd50500),
      key_event(OP_NOTE_ON, 3, 42, 48'hFFFF_FFFF_0000),
      key_event(OP_TICK, 0, 127, 48'hFFFF_FFFF_FFFF),
      key_event(OP_NOTE_ON, 9, 85, 48'd0),
      key_event(OP_CLEAR, 15, 127, 48'h5555_5555_5555),
      key_event(OP_NOTE_OFF, 2, 10, 48'd10),
      key_event(OP_SUSTAIN_ON, 2, 0, 48'd20),
      key_event(OP_NOTE_ON, 2, 10, 48'd30),
      key_event(OP_NOTE_OFF, 2, 10, 48'd40),
      key_event(OP_NOTE_ON, 2, 10, 48'd50),
      key_event(OP_NOTE_OFF, 2, 10, 48'd60),
      key_event(OP_NOTE_ON, 2, 100, 48'hAAAA_AAAA_AAAA),
      key_event(OP_CLEAR, 0, 0, 48'd0)
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (opening[i]) send_event(opening[i], i == opening.size() - 1);
    event_clock = '0;
    for (int p = 0; p < 7; p++) begin
      wait_drained();
      apply_setting(windows[p], leasts[p]);
      for (int i = 0; i < per_phase; i++) begin
        stop_here = (p == 2 && i == 100);
        send_event(random_event(), stop_here || i == per_phase - 1);
        if (stop_here) wait_drained();
      end
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
